### src/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// shared types, constants and the sort key compare for the record sorter
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int ID_W          = 32;
  localparam int SCORE_W       = 10;
  localparam int TOTAL_W       = 13;
  localparam int POS_W         = 6;
  localparam int SCORE_INPUTS  = 6;
  localparam int MODE_W        = 2;
  localparam int COURSE_W      = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 3;

  localparam int DEF_MAX_RECORDS = 32;
  localparam int DEF_MAX_SCORES  = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SORT_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COURSE_COUNT = 1'd1;

  // sort modes, anything else sorts by identifier
  localparam logic [MODE_W-1:0] MODE_TOTAL_DESC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TOTAL_ASC  = 2'd1;

  localparam logic [MODE_W-1:0]   RESET_SORT_MODE    = MODE_TOTAL_DESC;
  localparam logic [COURSE_W-1:0] RESET_COURSE_COUNT = 3'd6;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TOTAL_W-1:0] total;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic [MODE_W-1:0]   sort_mode;
    logic [COURSE_W-1:0] course_count;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
    rec_t rec;
  } load_t;

  // true if cand should replace the current pick, strict so ties keep the pick
  function automatic logic rss_better(logic [MODE_W-1:0] mode, rec_t pick, rec_t cand);
    logic res;
    unique case (mode)
      MODE_TOTAL_DESC: res = pick.total < cand.total;
      MODE_TOTAL_ASC:  res = pick.total > cand.total;
      default:         res = cand.id < pick.id;
    endcase
    return res;
  endfunction

endpackage

### src/rss_if.sv
// ----------------------------------------------------------------------------
// rss_if
// valid/ready channels for record words in and sorted words out
// ----------------------------------------------------------------------------
interface rss_in_if;
  logic                        valid;
  logic                        ready;
  logic [rss_pkg::ID_W-1:0]    id_number;
  logic [rss_pkg::SCORE_W-1:0] score_0;
  logic [rss_pkg::SCORE_W-1:0] score_1;
  logic [rss_pkg::SCORE_W-1:0] score_2;
  logic [rss_pkg::SCORE_W-1:0] score_3;
  logic [rss_pkg::SCORE_W-1:0] score_4;
  logic [rss_pkg::SCORE_W-1:0] score_5;
  logic                        last_record;

  modport source (output valid, id_number, score_0, score_1, score_2, score_3,
                  score_4, score_5, last_record, input ready);
  modport sink   (input valid, id_number, score_0, score_1, score_2, score_3,
                  score_4, score_5, last_record, output ready);
endinterface

interface rss_out_if;
  logic                        valid;
  logic                        ready;
  logic [rss_pkg::POS_W-1:0]   position;
  logic [rss_pkg::ID_W-1:0]    out_id;
  logic [rss_pkg::TOTAL_W-1:0] out_total;
  logic                        last_out;

  modport source (output valid, position, out_id, out_total, last_out, input ready);
  modport sink   (input valid, position, out_id, out_total, last_out, output ready);
endinterface

### src/rss_ram.sv
// ----------------------------------------------------------------------------
// rss_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/rss_engine.sv
// ----------------------------------------------------------------------------
// rss_engine
// load sequencer and selection sort over the record ram, one pass per rank
// ----------------------------------------------------------------------------
module rss_engine #(
  parameter int MAX_RECORDS = rss_pkg::DEF_MAX_RECORDS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rss_pkg::cfg_t                  cfg,
  input  rss_pkg::load_t                 load,
  output logic                           load_ready,
  output logic                           ram_we,
  output logic [$clog2(MAX_RECORDS)-1:0] ram_waddr,
  output rss_pkg::rec_t                  ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(MAX_RECORDS)-1:0] ram_raddr,
  input  rss_pkg::rec_t                  ram_rdata,
  rss_out_if.source                      out_ch
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  rss_pkg::rec_t pick_r, pick_nxt;
  rss_pkg::rec_t icur_r, icur_nxt;

  logic                    out_vld_r, out_vld_nxt;
  rss_pkg::rec_t           out_rec_r, out_rec_nxt;
  logic [rss_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic                    out_last_r, out_last_nxt;

  logic          out_load;
  logic [CW-1:0] i_plus1;
  logic          last_rank;

  assign i_plus1   = CW'(i_r) + CW'(1);
  assign last_rank = (i_plus1 == count_r);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    rd_vld_nxt   = rd_vld_r;
    rd_idx_nxt   = rd_idx_r;
    pick_nxt     = pick_r;
    icur_nxt     = icur_r;
    out_vld_nxt  = out_vld_r;
    out_rec_nxt  = out_rec_r;
    out_pos_nxt  = out_pos_r;
    out_last_nxt = out_last_r;
    out_load     = 1'b0;
    load_ready   = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = count_r[AW-1:0];
    ram_wdata    = load.rec;
    ram_re       = 1'b0;
    ram_raddr    = j_r[AW-1:0];

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        load_ready = 1'b1;
        if (load.valid) begin
          // full store drops the word but still honors last
          if (count_r < CW'(MAX_RECORDS)) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          if (load.last) begin
            state_nxt  = ST_SCAN;
            i_nxt      = '0;
            j_nxt      = '0;
            rd_vld_nxt = 1'b0;
          end
        end
      end

      ST_SCAN: begin
        // compare the word returned by last cycle's read
        if (rd_vld_r) begin
          if (rd_idx_r == i_r) begin
            pick_nxt = ram_rdata;
            icur_nxt = ram_rdata;
            k_nxt    = i_r;
          end else if (rss_pkg::rss_better(cfg.sort_mode, pick_r, ram_rdata)) begin
            pick_nxt = ram_rdata;
            k_nxt    = rd_idx_r;
          end
        end
        if (j_r < count_r) begin
          ram_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = j_r[AW-1:0];
          j_nxt      = j_r + CW'(1);
        end else begin
          rd_vld_nxt = 1'b0;
          state_nxt  = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load     = 1'b1;
          // swap: the old occupant of rank i moves to the pick's slot
          ram_we       = 1'b1;
          ram_waddr    = k_r;
          ram_wdata    = icur_r;
          out_vld_nxt  = 1'b1;
          out_rec_nxt  = pick_r;
          out_pos_nxt  = rss_pkg::POS_W'(i_plus1);
          out_last_nxt = last_rank;
          if (last_rank) begin
            state_nxt = ST_IDLE;
            count_nxt = '0;
          end else begin
            i_nxt     = i_plus1[AW-1:0];
            j_nxt     = i_plus1;
            state_nxt = ST_SCAN;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pick_r     <= pick_nxt;
    icur_r     <= icur_nxt;
    out_rec_r  <= out_rec_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.out_id    = out_rec_r.id;
  assign out_ch.out_total = out_rec_r.total;
  assign out_ch.last_out  = out_last_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RECORDS))
    else $error("record count above capacity");

  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> CW'(i_r) < count_r)
    else $error("rank index outside stored records");

  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN) && (CW'(rd_idx_r) < count_r))
    else $error("pending read outside scan or stored records");

  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> (k_r >= i_r) && (CW'(k_r) < count_r))
    else $error("pick slot outside unsorted range");

  a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && last_rank |=> (state_r == ST_IDLE) && (count_r == '0))
    else $error("store not emptied after final rank");

endmodule

### src/record_selection_sort_top.sv
// ----------------------------------------------------------------------------
// record_selection_sort_top
// loads scored records, then emits them ranked by selection sort
// ----------------------------------------------------------------------------
// loading: one word per cycle, ready whenever no sort run is in progress
// sorting: each rank scans the unsorted entries through the ram's registered read,
//   then emits the pick and swaps it into place; a stall on the output side holds the emit
// reset: synchronous active low, empties the store, sort_mode 0, course_count 6;
//   ram contents are left as they are, only entries below the count are read
// ----------------------------------------------------------------------------
module record_selection_sort_top #(
  parameter int MAX_RECORDS = rss_pkg::DEF_MAX_RECORDS,
  parameter int MAX_SCORES  = rss_pkg::DEF_MAX_SCORES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data,
  rss_in_if.sink                         in_ch,
  rss_out_if.source                      out_ch
);

  localparam int AW = $clog2(MAX_RECORDS);

  // configuration registers
  rss_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sort_mode    <= rss_pkg::RESET_SORT_MODE;
      cfg_r.course_count <= rss_pkg::RESET_COURSE_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rss_pkg::REG_SORT_MODE:    cfg_r.sort_mode    <= cfg_data[rss_pkg::MODE_W-1:0];
        rss_pkg::REG_COURSE_COUNT: cfg_r.course_count <= cfg_data[rss_pkg::COURSE_W-1:0];
        default: ;
      endcase
    end
  end

  // record total: add the leading scores, count capped at the build limit
  logic [rss_pkg::SCORE_W-1:0] scores [rss_pkg::SCORE_INPUTS];
  logic [rss_pkg::COURSE_W:0]  score_limit;
  logic [rss_pkg::TOTAL_W-1:0] total;

  assign scores[0] = in_ch.score_0;
  assign scores[1] = in_ch.score_1;
  assign scores[2] = in_ch.score_2;
  assign scores[3] = in_ch.score_3;
  assign scores[4] = in_ch.score_4;
  assign scores[5] = in_ch.score_5;

  always_comb begin
    if ({1'b0, cfg_r.course_count} > (rss_pkg::COURSE_W + 1)'(MAX_SCORES)) begin
      score_limit = (rss_pkg::COURSE_W + 1)'(MAX_SCORES);
    end else begin
      score_limit = {1'b0, cfg_r.course_count};
    end
    total = '0;
    for (int s = 0; s < rss_pkg::SCORE_INPUTS; s++) begin
      if ((rss_pkg::COURSE_W + 1)'(s) < score_limit) begin
        total = total + rss_pkg::TOTAL_W'(scores[s]);
      end
    end
  end

  // load word to the sequencer
  rss_pkg::load_t load;
  logic           load_ready;

  assign load.valid     = in_ch.valid;
  assign load.last      = in_ch.last_record;
  assign load.rec.id    = in_ch.id_number;
  assign load.rec.total = total;
  assign in_ch.ready    = load_ready;

  // record store
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  rss_pkg::rec_t ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  rss_pkg::rec_t ram_rdata;

  rss_ram #(
    .WIDTH (rss_pkg::REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // load sequencer and sort passes
  rss_engine #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .load       (load),
    .load_ready (load_ready),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_ch     (out_ch)
  );

endmodule

### dv/record_selection_sort_top_test.sv
// ----------------------------------------------------------------------------
// record_selection_sort_top_test
// self-checking bench for the record sorter: loads runs of scored records,
// ranks them in a local model of the sort and checks every ranked word
// ----------------------------------------------------------------------------
module record_selection_sort_top_test;
  import rss_pkg::*;

  localparam int MAX_RECORDS  = DEF_MAX_RECORDS;
  localparam int MAX_SCORES   = DEF_MAX_SCORES;
  localparam int RANDOM_ITEMS = 180;
  // long output hold-off, the sort run backs up into the loader
  localparam int HOLD_CYCLES  = 400;
  // quiet cycles after the last ranked word before touching registers
  localparam int DRAIN_CYCLES = 40;
  localparam int TAIL_CYCLES  = 50;
  // cycles with no word moving on either side before giving up
  localparam int STALL_LIMIT  = 4000;

  // identifier modes, the spare code sorts by identifier as well
  localparam logic [MODE_W-1:0] MODE_ID_ASC   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ID_SPARE = 2'd3;

  typedef logic [SCORE_INPUTS-1:0][SCORE_W-1:0] score_set_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    score_set_t      scores;
    logic            last;
  } record_word_t;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [ID_W-1:0]    id;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } ranked_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rss_in_if  in_ch ();
  rss_out_if out_ch ();

  record_selection_sort_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // 10 unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- local model of the sorter ----

  // register copies
  logic [MODE_W-1:0]   mirror_mode;
  logic [COURSE_W-1:0] mirror_courses;

  // records waiting for the final word of a run
  logic [ID_W-1:0]     kept_id    [MAX_RECORDS];
  logic [TOTAL_W-1:0]  kept_total [MAX_RECORDS];
  int                  kept_count = 0;

  // ranked words still to come out, oldest first
  ranked_word_t        ranked_q [$];

  int error_count   = 0;
  int items_sent    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int stall_cycles  = 0;

  // scores of the previous random record, reused to force equal totals
  score_set_t prev_scores = '0;

  // sum of the leading scores, count capped at the score inputs
  function automatic logic [TOTAL_W-1:0] course_total(score_set_t scores);
    int                 n;
    logic [TOTAL_W-1:0] sum;
    n = int'(mirror_courses);
    if (n > MAX_SCORES) n = MAX_SCORES;
    if (n > SCORE_INPUTS) n = SCORE_INPUTS;
    sum = '0;
    for (int j = 0; j < n; j++) sum = sum + TOTAL_W'(scores[j]);
    return sum;
  endfunction

  // strict compare, so a tie never moves the current pick
  function automatic logic replaces(logic [ID_W-1:0] pick_id, logic [TOTAL_W-1:0] pick_total,
                                    logic [ID_W-1:0] cand_id, logic [TOTAL_W-1:0] cand_total);
    case (mirror_mode)
      MODE_TOTAL_DESC: return pick_total < cand_total;
      MODE_TOTAL_ASC:  return pick_total > cand_total;
      default:         return cand_id < pick_id;
    endcase
  endfunction

  // selection sort with swap, each rank is final once swapped into place
  function automatic void rank_records();
    int                 k;
    logic [ID_W-1:0]    t_id;
    logic [TOTAL_W-1:0] t_total;
    ranked_word_t       w;
    for (int i = 0; i < kept_count; i++) begin
      k = i;
      for (int j = i + 1; j < kept_count; j++)
        if (replaces(kept_id[k], kept_total[k], kept_id[j], kept_total[j])) k = j;
      t_id          = kept_id[k];
      t_total       = kept_total[k];
      kept_id[k]    = kept_id[i];
      kept_total[k] = kept_total[i];
      kept_id[i]    = t_id;
      kept_total[i] = t_total;
      w.position    = POS_W'(i + 1);
      w.id          = kept_id[i];
      w.total       = kept_total[i];
      w.last        = (i == kept_count - 1);
      ranked_q.push_back(w);
    end
    kept_count = 0;
  endfunction

  // one accepted record: store it unless full, rank on the final one
  function automatic void load_record(record_word_t w);
    if (kept_count < MAX_RECORDS) begin
      kept_id[kept_count]    = w.id;
      kept_total[kept_count] = course_total(w.scores);
      kept_count++;
    end
    if (w.last) rank_records();
  endfunction

  // ---- checking ----

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    // keep the log short when everything goes wrong
    if (error_count <= 100)
      $display("mismatch in %s: got 'h%0h, expected 'h%0h", what, got, want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // output words checked first, then the input word feeds the model;
  // values read here are the ones the block saw at this edge
  always @(posedge clk) begin
    record_word_t seen;
    ranked_word_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (ranked_q.size() == 0) begin
          report_mismatch("unexpected word, id", 64'(out_ch.out_id), '0);
        end else begin
          want = ranked_q.pop_front();
          check_field("position", 64'(out_ch.position), 64'(want.position));
          check_field("out_id", 64'(out_ch.out_id), 64'(want.id));
          check_field("out_total", 64'(out_ch.out_total), 64'(want.total));
          check_field("last_out", 64'(out_ch.last_out), 64'(want.last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.id        = in_ch.id_number;
        seen.scores[0] = in_ch.score_0;
        seen.scores[1] = in_ch.score_1;
        seen.scores[2] = in_ch.score_2;
        seen.scores[3] = in_ch.score_3;
        seen.scores[4] = in_ch.score_4;
        seen.scores[5] = in_ch.score_5;
        seen.last      = in_ch.last_record;
        load_record(seen);
      end
    end
  end

  // receiver: random back-pressure, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      out_ch.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles where no word moves at all
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---- stimulus helpers ----

  // offer one record and hold it until taken; valid stays high on return
  // so a following word goes out back to back
  task automatic send_record(record_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.id_number   <= w.id;
    in_ch.score_0     <= w.scores[0];
    in_ch.score_1     <= w.scores[1];
    in_ch.score_2     <= w.scores[2];
    in_ch.score_3     <= w.scores[3];
    in_ch.score_4     <= w.scores[4];
    in_ch.score_5     <= w.scores[5];
    in_ch.last_record <= w.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // drop valid, let every ranked word out, then give the block time to settle
  task automatic drain_and_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers, back to back, only with the block idle
  task automatic set_config(logic [MODE_W-1:0] mode, logic [COURSE_W-1:0] courses);
    drain_and_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SORT_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= REG_COURSE_COUNT;
    cfg_data  <= courses;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mirror_mode    = mode;
    mirror_courses = courses;
  endtask

  function automatic record_word_t make_record(logic [ID_W-1:0] id, score_set_t scores,
                                               logic last);
    record_word_t w;
    w.id     = id;
    w.scores = scores;
    w.last   = last;
    return w;
  endfunction

  function automatic logic [SCORE_W-1:0] random_score();
    case ($urandom_range(0, 3))
      0: return SCORE_W'($urandom_range(0, 1023));
      1: return SCORE_W'($urandom_range(0, 1000));
      2: begin
        case ($urandom_range(0, 3))
          0: return 10'd0;
          1: return 10'd500;
          2: return 10'd1000;
          default: return 10'd1023;
        endcase
      end
      default: return SCORE_W'($urandom_range(0, 3));
    endcase
  endfunction

  // random content with plenty of equal identifiers and equal totals
  function automatic record_word_t random_record();
    record_word_t w;
    case ($urandom_range(0, 3))
      0: w.id = $urandom_range(0, 7);
      1: w.id = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: w.id = $urandom();
    endcase
    if ($urandom_range(0, 3) == 0) begin
      w.scores = prev_scores;
    end else begin
      for (int j = 0; j < SCORE_INPUTS; j++) w.scores[j] = random_score();
    end
    prev_scores = w.scores;
    w.last      = 1'b0;
    return w;
  endfunction

  // n random records, the final one closes the run
  task automatic send_run(int n);
    record_word_t w;
    for (int i = 0; i < n; i++) begin
      w      = random_record();
      w.last = (i == n - 1);
      send_record(w);
    end
  endtask

  // ---- tests ----

  // reset values: total descending over all six scores, field extremes
  task automatic test_reset_defaults();
    send_record(make_record(32'hFFFF_FFFF, {6{10'h3FF}}, 1'b0));
    send_record(make_record(32'h0000_0000, {6{10'h000}}, 1'b0));
    send_record(make_record(32'h5555_5555, {6{10'h155}}, 1'b0));
    send_record(make_record(32'hAAAA_AAAA, {6{10'h2AA}}, 1'b0));
    send_record(make_record(32'h0000_0001, {6{10'd1000}}, 1'b0));
    // equal total to the alternating pattern above
    send_record(make_record(32'h0000_0003, {6{10'h155}}, 1'b1));
  endtask

  // a run of one record ranks it alone
  task automatic test_single_record();
    set_config(MODE_ID_ASC, 3'd3);
    send_record(make_record(32'h1234_5678, {10'd7, 10'd6, 10'd5, 10'd4, 10'd3, 10'd2}, 1'b1));
  endtask

  // every sort mode, with equal keys and the odd course counts
  task automatic test_sort_modes();
    // no course counted, every total zero, all keys tie
    set_config(MODE_TOTAL_ASC, 3'd0);
    send_record(make_record(32'd9, {6{10'd100}}, 1'b0));
    send_record(make_record(32'd3, {6{10'd900}}, 1'b0));
    send_record(make_record(32'd7, {6{10'h3FF}}, 1'b0));
    send_record(make_record(32'd3, {6{10'd1}}, 1'b1));
    // count above the score inputs, repeated identifiers
    set_config(MODE_ID_ASC, 3'd7);
    send_record(make_record(32'd5, {10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6}, 1'b0));
    send_record(make_record(32'd5, {6{10'd10}}, 1'b0));
    send_record(make_record(32'd1, {6{10'd20}}, 1'b0));
    send_record(make_record(32'd5, {6{10'd30}}, 1'b1));
    // spare mode code, single course
    set_config(MODE_ID_SPARE, 3'd1);
    send_record(make_record(32'hFFFF_FFFF, {10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd12}, 1'b0));
    send_record(make_record(32'h0000_0000, {6{10'd40}}, 1'b0));
    send_record(make_record(32'h8000_0000, {6{10'h3FF}}, 1'b0));
    send_record(make_record(32'h0000_0000, {6{10'd41}}, 1'b1));
    // descending totals with ties, swaps reorder equal ones
    set_config(MODE_TOTAL_DESC, 3'd6);
    send_record(make_record(32'd11, {6{10'd10}}, 1'b0));
    send_record(make_record(32'd12, {6{10'd20}}, 1'b0));
    send_record(make_record(32'd13, {6{10'd20}}, 1'b0));
    send_record(make_record(32'd14, {6{10'd10}}, 1'b0));
    send_record(make_record(32'd15, {6{10'd20}}, 1'b1));
  endtask

  // more records than the store holds, then exactly a full store
  task automatic test_store_full();
    set_config(MODE_TOTAL_ASC, 3'd2);
    // the closing record is itself dropped but still starts the sort
    send_run(MAX_RECORDS + 2);
    send_run(MAX_RECORDS);
  endtask

  // receiver stops for a long stretch while the sender keeps offering
  task automatic test_output_hold_off();
    set_config(MODE_ID_ASC, 3'd6);
    send_idle_pct = 0;
    hold_req     <= hold_req + 1;
    send_run(20);
    send_run(12);
  endtask

  // random runs, mostly short, now and then a full or overfull store
  task automatic test_random_runs();
    int target;
    int pick;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 21; recv_idle_pct = 56; end
        1: begin send_idle_pct = 56; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      target = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < target) begin
        if ($urandom_range(0, 3) == 0)
          set_config(MODE_W'($urandom_range(0, 3)), COURSE_W'($urandom_range(0, 7)));
        pick = $urandom_range(0, 19);
        if (pick == 0)
          send_run($urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 8));
        else if (pick < 3)
          send_run($urandom_range(9, MAX_RECORDS));
        else
          send_run($urandom_range(1, 8));
      end
    end
  endtask

  // ---- sequence ----

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.id_number   <= '0;
    in_ch.score_0     <= '0;
    in_ch.score_1     <= '0;
    in_ch.score_2     <= '0;
    in_ch.score_3     <= '0;
    in_ch.score_4     <= '0;
    in_ch.score_5     <= '0;
    in_ch.last_record <= 1'b0;
    mirror_mode    = RESET_SORT_MODE;
    mirror_courses = RESET_COURSE_COUNT;
    send_idle_pct  = 21;
    recv_idle_pct  = 56;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_single_record();
    test_sort_modes();
    test_store_full();
    test_output_hold_off();
    test_random_runs();

    // everything ranked has to come out, then a quiet tail
    drain_and_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
